### rtl/core/positional_insert_delete_list_unit_macros.svh
// assertion macros for the list unit rtl
`ifndef POSITIONAL_INSERT_DELETE_LIST_UNIT_MACROS_SVH
`define POSITIONAL_INSERT_DELETE_LIST_UNIT_MACROS_SVH

// clocked check, off while reset is held
`define PIDL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// clocked check that also holds during reset
`define PIDL_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### rtl/core/pidl_pkg.sv
// shared constants and codes for the positional list unit
package pidl_pkg;

  // store geometry
  localparam int DEPTH  = 64;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = 7;

  // field widths
  localparam int VAL_W  = 32;
  localparam int POS_W  = 7;

  // operation codes
  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_DUMP   = 2'd2,
    OP_NOP    = 2'd3
  } op_t;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_BADPOS = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_FULL   = 2'd3
  } status_t;

endpackage

### rtl/core/positional_insert_delete_list_unit.sv
// positional insert/delete list: sequencer, fill count and entry store
//
//  channel | ports                  | word contents
//  --------+------------------------+--------------------------------------------
//  input   | in_tvalid/tready/tdata | op, position, value
//  result  | out_tvalid/tready/...  | status, entry, fill; tlast on final word
//
// insert walks entries up one cell per step, each step a ram read then a
// write; delete likewise walks down; dump reads each entry, then hands it to
// the output register. the single ram read/write port pair sets this stepping.
// rst_n clears fill, sequencer and out_tvalid; the store needs no clearing.
// results sit in an output register, so a new word is taken while one waits;
// a stalled result word holds the sequencer in its output state.
`include "positional_insert_delete_list_unit_macros.svh"

module positional_insert_delete_list_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // [1:0] op, [8:2] position, [40:9] value, rest zero
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // [1:0] status, [33:2] entry, [40:34] fill, rest zero
  output logic        out_tlast
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_RD,
    S_INS_WR,
    S_DEL_RD,
    S_DEL_WR,
    S_DUMP_RD,
    S_DUMP_WR,
    S_DONE
  } state_t;

  state_t                               state_r, state_nxt;
  logic [pidl_pkg::CNT_W-1:0]           cnt_r, cnt_nxt;
  logic [pidl_pkg::ADDR_W-1:0]          ptr_r, ptr_nxt;
  logic [pidl_pkg::ADDR_W-1:0]          tgt_r, tgt_nxt;
  logic [pidl_pkg::VAL_W-1:0]           val_r, val_nxt;
  pidl_pkg::status_t                    res_r, res_nxt;

  logic                                 out_valid_r, out_valid_nxt;
  pidl_pkg::status_t                    out_status_r, out_status_nxt;
  logic [pidl_pkg::VAL_W-1:0]           out_entry_r, out_entry_nxt;
  logic [pidl_pkg::CNT_W-1:0]           out_fill_r, out_fill_nxt;
  logic                                 out_last_r, out_last_nxt;

  // input word fields
  pidl_pkg::op_t                        in_op;
  logic [pidl_pkg::POS_W-1:0]           in_pos;
  logic [pidl_pkg::VAL_W-1:0]           in_val;
  logic [pidl_pkg::POS_W-1:0]           in_pos_m1;
  logic                                 in_acc;

  // shared step unit
  logic                                 step_dec;
  logic [pidl_pkg::CNT_W-1:0]           step_sum;
  logic                                 out_free;

  // ram port
  logic                                 ram_wr_en;
  logic [pidl_pkg::ADDR_W-1:0]          ram_wr_addr;
  logic [pidl_pkg::VAL_W-1:0]           ram_wr_data;
  logic                                 ram_rd_en;
  logic [pidl_pkg::ADDR_W-1:0]          ram_rd_addr;
  logic [pidl_pkg::VAL_W-1:0]           ram_rd_data;
  logic                                 dump_rd;

  assign in_op     = pidl_pkg::op_t'(in_tdata[1:0]);
  assign in_pos    = in_tdata[8:2];
  assign in_val    = in_tdata[40:9];
  assign in_pos_m1 = in_pos - pidl_pkg::POS_W'(1);
  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;

  // one adder moves the pointer up or down a cell
  assign step_dec = (state_r == S_INS_RD) || (state_r == S_INS_WR);
  assign step_sum = {{(pidl_pkg::CNT_W-pidl_pkg::ADDR_W){1'b0}}, ptr_r}
                  + (step_dec ? {pidl_pkg::CNT_W{1'b1}} : pidl_pkg::CNT_W'(1));

  // dump reads cell ptr itself, the shifts read its neighbor
  assign dump_rd     = (state_r == S_DUMP_RD);
  assign ram_rd_addr = dump_rd ? ptr_r : step_sum[pidl_pkg::ADDR_W-1:0];

  // entry store
  pidl_ram #(
    .WIDTH (pidl_pkg::VAL_W),
    .DEPTH (pidl_pkg::DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  // sequencer next state
  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    ptr_nxt        = ptr_r;
    tgt_nxt        = tgt_r;
    val_nxt        = val_r;
    res_nxt        = res_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_status_nxt = out_status_r;
    out_entry_nxt  = out_entry_r;
    out_fill_nxt   = out_fill_r;
    out_last_nxt   = out_last_r;
    ram_wr_en      = 1'b0;
    ram_wr_addr    = ptr_r;
    ram_wr_data    = ram_rd_data;
    ram_rd_en      = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = S_DONE;
          val_nxt   = in_val;
          case (in_op)
            pidl_pkg::OP_INSERT: begin
              if (in_pos == '0 ||
                  {1'b0, in_pos} > ({1'b0, cnt_r} + (pidl_pkg::CNT_W + 1)'(1))) begin
                res_nxt = pidl_pkg::ST_BADPOS;
              end else if (cnt_r == pidl_pkg::CNT_W'(pidl_pkg::DEPTH)) begin
                res_nxt = pidl_pkg::ST_FULL;
              end else begin
                res_nxt   = pidl_pkg::ST_OK;
                ptr_nxt   = cnt_r[pidl_pkg::ADDR_W-1:0];
                tgt_nxt   = in_pos_m1[pidl_pkg::ADDR_W-1:0];
                state_nxt = S_INS_RD;
              end
            end
            pidl_pkg::OP_DELETE: begin
              if (cnt_r == '0) begin
                res_nxt = pidl_pkg::ST_EMPTY;
              end else if (in_pos == '0 || in_pos > cnt_r) begin
                res_nxt = pidl_pkg::ST_BADPOS;
              end else begin
                res_nxt   = pidl_pkg::ST_OK;
                ptr_nxt   = in_pos_m1[pidl_pkg::ADDR_W-1:0];
                state_nxt = S_DEL_RD;
              end
            end
            pidl_pkg::OP_DUMP: begin
              if (cnt_r == '0) begin
                res_nxt = pidl_pkg::ST_EMPTY;
              end else begin
                ptr_nxt   = '0;
                state_nxt = S_DUMP_RD;
              end
            end
            default: begin
              res_nxt = pidl_pkg::ST_OK;
            end
          endcase
        end
      end

      // insert: copy cell ptr-1 up to ptr until the target is reached
      S_INS_RD: begin
        if (ptr_r == tgt_r) begin
          ram_wr_en   = 1'b1;
          ram_wr_data = val_r;
          cnt_nxt     = cnt_r + pidl_pkg::CNT_W'(1);
          state_nxt   = S_DONE;
        end else begin
          ram_rd_en = 1'b1;
          state_nxt = S_INS_WR;
        end
      end
      S_INS_WR: begin
        ram_wr_en = 1'b1;
        ptr_nxt   = step_sum[pidl_pkg::ADDR_W-1:0];
        state_nxt = S_INS_RD;
      end

      // delete: copy cell ptr+1 down to ptr until the end of the list
      S_DEL_RD: begin
        if (step_sum == cnt_r) begin
          cnt_nxt   = cnt_r - pidl_pkg::CNT_W'(1);
          state_nxt = S_DONE;
        end else begin
          ram_rd_en = 1'b1;
          state_nxt = S_DEL_WR;
        end
      end
      S_DEL_WR: begin
        ram_wr_en = 1'b1;
        ptr_nxt   = step_sum[pidl_pkg::ADDR_W-1:0];
        state_nxt = S_DEL_RD;
      end

      // dump: read cell ptr, then hand it to the output register
      S_DUMP_RD: begin
        ram_rd_en = 1'b1;
        state_nxt = S_DUMP_WR;
      end
      S_DUMP_WR: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = pidl_pkg::ST_OK;
          out_entry_nxt  = ram_rd_data;
          out_fill_nxt   = cnt_r;
          out_last_nxt   = (step_sum == cnt_r);
          ptr_nxt        = step_sum[pidl_pkg::ADDR_W-1:0];
          state_nxt      = (step_sum == cnt_r) ? S_IDLE : S_DUMP_RD;
        end
      end

      // single result word of insert, delete, empty dump or unused op
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_r;
          out_entry_nxt  = '0;
          out_fill_nxt   = cnt_r;
          out_last_nxt   = 1'b1;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    ptr_r        <= ptr_nxt;
    tgt_r        <= tgt_nxt;
    val_r        <= val_nxt;
    res_r        <= res_nxt;
    out_status_r <= out_status_nxt;
    out_entry_r  <= out_entry_nxt;
    out_fill_r   <= out_fill_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {7'd0, out_fill_r, out_entry_r, out_status_r};

  // fill count never passes the store depth
  `PIDL_ASSERT(a_cnt_range, cnt_r <= pidl_pkg::CNT_W'(pidl_pkg::DEPTH), "fill above depth")
  // an error status always ends its word run
  `PIDL_ASSERT(a_err_last,
               out_valid_r && out_status_r != pidl_pkg::ST_OK |-> out_last_r,
               "error word not last")
  // only dump words carry a nonzero entry, and those are ok
  `PIDL_ASSERT(a_entry_ok,
               out_valid_r && out_entry_r != '0 |-> out_status_r == pidl_pkg::ST_OK,
               "entry on error word")
  // fill count moves by at most one per cycle
  `PIDL_ASSERT(a_cnt_step,
               $past(rst_n) && cnt_r != $past(cnt_r) |->
                 (cnt_r == $past(cnt_r) + pidl_pkg::CNT_W'(1) ||
                  cnt_r == $past(cnt_r) - pidl_pkg::CNT_W'(1)),
               "fill jumped")
  // the store is never written while waiting for input
  `PIDL_ASSERT_ALWAYS(a_idle_no_wr, state_r == S_IDLE |-> !ram_wr_en, "store write while idle")

endmodule

### rtl/core/pidl_ram.sv
// generic single write port ram with registered read
module pidl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                                    clk,
  input  logic                                    wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                        wr_data,
  input  logic                                    rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                        rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // read port, data held until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem_r[rd_addr];
    end
  end

endmodule

### tb/pidl_list_monitor.sv
// list unit monitor: shadow list, expected result words and comparison
module pidl_list_monitor (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [47:0] in_tdata,   // [1:0] op, [8:2] position, [40:9] value, rest zero
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [47:0] out_tdata,  // [1:0] status, [33:2] entry, [40:34] fill, rest zero
  input  logic        out_tlast,
  output int          mismatch_count,
  output int          pending_words,
  output logic [6:0]  list_fill
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    pidl_pkg::status_t status;
    logic [31:0]       entry;
    logic [6:0]        fill;
    logic              last;
  } list_word_t;

  // shadow copy of the store and its fill count
  logic [31:0] shadow_list [pidl_pkg::DEPTH];
  int          shadow_fill;

  // result words still owed by the unit, oldest first
  list_word_t  words_due [$];
  list_word_t  want;

  // apply one accepted word to the shadow list and queue what it must produce
  task automatic predict_list_op(input pidl_pkg::op_t op, input logic [6:0] pos,
                                 input logic [31:0] value);
    list_word_t w;
    int p;
    int k;
    bit streamed;
    p = pos;
    streamed = 0;
    w.status = pidl_pkg::ST_OK;
    w.entry  = '0;
    w.fill   = shadow_fill[6:0];
    w.last   = 1'b1;
    case (op)
      pidl_pkg::OP_INSERT: begin
        // position is checked before fullness
        if (p < 1 || p > shadow_fill + 1) begin
          w.status = pidl_pkg::ST_BADPOS;
        end else if (shadow_fill >= pidl_pkg::DEPTH) begin
          w.status = pidl_pkg::ST_FULL;
        end else begin
          for (k = shadow_fill; k >= p; k--) shadow_list[k] = shadow_list[k-1];
          shadow_list[p-1] = value;
          shadow_fill++;
          w.fill = shadow_fill[6:0];
        end
      end
      pidl_pkg::OP_DELETE: begin
        // emptiness is checked before the position
        if (shadow_fill == 0) begin
          w.status = pidl_pkg::ST_EMPTY;
        end else if (p < 1 || p > shadow_fill) begin
          w.status = pidl_pkg::ST_BADPOS;
        end else begin
          for (k = p - 1; k + 1 < shadow_fill; k++) shadow_list[k] = shadow_list[k+1];
          shadow_fill--;
          w.fill = shadow_fill[6:0];
        end
      end
      pidl_pkg::OP_DUMP: begin
        if (shadow_fill == 0) begin
          w.status = pidl_pkg::ST_EMPTY;
        end else begin
          streamed = 1;
          for (k = 0; k < shadow_fill; k++) begin
            w.entry = shadow_list[k];
            w.last  = (k + 1 == shadow_fill);
            words_due.push_back(w);
          end
        end
      end
      default: ;
    endcase
    if (!streamed) words_due.push_back(w);
  endtask

  // sample both channels at the rising edge
  always @(posedge clk) begin
    if (!rst_n) begin
      shadow_fill = 0;
      words_due.delete();
    end else begin
      if (in_tvalid && in_tready)
        predict_list_op(pidl_pkg::op_t'(in_tdata[1:0]), in_tdata[8:2], in_tdata[40:9]);
      if (out_tvalid && out_tready) begin
        if (words_due.size() == 0) begin
          $error("unexpected result word: status %0d entry %0d fill %0d last %0b",
                 out_tdata[1:0], $signed(out_tdata[33:2]), out_tdata[40:34], out_tlast);
          mismatch_count++;
        end else begin
          want = words_due.pop_front();
          if (out_tdata[1:0] !== want.status) begin
            $error("status mismatch: expected %0d, got %0d", want.status, out_tdata[1:0]);
            mismatch_count++;
          end
          if (out_tdata[33:2] !== want.entry) begin
            $error("entry mismatch: expected %0d, got %0d",
                   $signed(want.entry), $signed(out_tdata[33:2]));
            mismatch_count++;
          end
          if (out_tdata[40:34] !== want.fill) begin
            $error("fill mismatch: expected %0d, got %0d", want.fill, out_tdata[40:34]);
            mismatch_count++;
          end
          if (out_tlast !== want.last) begin
            $error("last mismatch: expected %0b, got %0b", want.last, out_tlast);
            mismatch_count++;
          end
        end
      end
    end
    pending_words = words_due.size();
    list_fill     = shadow_fill[6:0];
  end

endmodule

### tb/tb_positional_insert_delete_list_unit.sv
// testbench top for the positional list unit: clock, reset, stimulus and verdict
module tb_positional_insert_delete_list_unit;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [47:0] in_tdata;   // [1:0] op, [8:2] position, [40:9] value, rest zero
  logic        out_tvalid;
  logic        out_tready;
  logic [47:0] out_tdata;  // [1:0] status, [33:2] entry, [40:34] fill, rest zero
  logic        out_tlast;

  int          mismatch_count;
  int          pending_words;
  logic [6:0]  list_fill;
  bit          no_idle;

  positional_insert_delete_list_unit uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  pidl_list_monitor mon (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .out_tlast      (out_tlast),
    .mismatch_count (mismatch_count),
    .pending_words  (pending_words),
    .list_fill      (list_fill)
  );

  // clock
  initial clk = 1'b0;
  always #2 clk = ~clk;

  // overall time limit
  initial begin
    #3_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  // value with a bias toward the extremes
  function automatic logic [31:0] pick_value();
    case ($urandom_range(9, 0))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return 32'h0000_0000;
      3:       return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  // offer one word after a random gap and hold it until taken
  task automatic send_word(input pidl_pkg::op_t op, input logic [6:0] pos,
                           input logic [31:0] value);
    int gap;
    gap = no_idle ? 0 : $urandom_range(3, 0);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {7'd0, value, pos, op};
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  // one random word; grow_pct sets how often a valid insert is chosen
  task automatic random_item(input int grow_pct);
    int r;
    int n;
    r = $urandom_range(99, 0);
    n = list_fill;
    if (r < grow_pct) begin
      send_word(pidl_pkg::OP_INSERT, 7'($urandom_range(n + 1, 1)), pick_value());
    end else if (r < grow_pct + 25) begin
      if (n > 0) send_word(pidl_pkg::OP_DELETE, 7'($urandom_range(n, 1)), $urandom);
      else send_word(pidl_pkg::OP_DELETE, 7'($urandom_range(127, 0)), $urandom);
    end else if (r < grow_pct + 33) begin
      send_word(pidl_pkg::OP_DUMP, 7'($urandom_range(127, 0)), $urandom);
    end else if (r < grow_pct + 36) begin
      send_word(pidl_pkg::OP_NOP, 7'($urandom_range(127, 0)), $urandom);
    end else begin
      // mostly out of range positions for insert or delete
      send_word($urandom_range(1, 0) ? pidl_pkg::OP_INSERT : pidl_pkg::OP_DELETE,
                7'($urandom_range(127, 0)), pick_value());
    end
  endtask

  // result side: random stall before each word
  initial begin
    int stall;
    out_tready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      stall = no_idle ? 0 : $urandom_range(3, 0);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      @(negedge clk);
    end
  end

  // stimulus and verdict
  initial begin
    int i;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    no_idle   = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // empty list corner cases
    send_word(pidl_pkg::OP_DUMP,   7'd0,   32'd0);
    send_word(pidl_pkg::OP_DELETE, 7'd0,   32'd0);
    send_word(pidl_pkg::OP_DELETE, 7'd127, 32'hffff_ffff);
    send_word(pidl_pkg::OP_INSERT, 7'd0,   32'd5);
    send_word(pidl_pkg::OP_INSERT, 7'd2,   32'd6);
    send_word(pidl_pkg::OP_INSERT, 7'd127, 32'hffff_ffff);
    // build a short list at front, end and middle
    send_word(pidl_pkg::OP_INSERT, 7'd1,   32'h8000_0000);
    send_word(pidl_pkg::OP_INSERT, 7'd2,   32'h7fff_ffff);
    send_word(pidl_pkg::OP_INSERT, 7'd1,   32'hffff_ffff);
    send_word(pidl_pkg::OP_INSERT, 7'd2,   32'h5555_5555);
    send_word(pidl_pkg::OP_INSERT, 7'd5,   32'haaaa_aaaa);
    send_word(pidl_pkg::OP_DUMP,   7'd0,   32'd0);
    // delete: out of range, middle, last, first
    send_word(pidl_pkg::OP_DELETE, 7'd0,   32'd0);
    send_word(pidl_pkg::OP_DELETE, 7'd6,   32'd0);
    send_word(pidl_pkg::OP_DELETE, 7'd127, 32'd0);
    send_word(pidl_pkg::OP_DELETE, 7'd3,   32'd0);
    send_word(pidl_pkg::OP_DELETE, 7'd4,   32'd0);
    send_word(pidl_pkg::OP_DELETE, 7'd1,   32'd0);
    // unused op code leaves the list alone
    send_word(pidl_pkg::OP_NOP,    7'd127, 32'hffff_ffff);
    send_word(pidl_pkg::OP_DUMP,   7'd127, 32'hffff_ffff);
    send_word(pidl_pkg::OP_INSERT, 7'd3,   32'd0);

    // mixed traffic with the list growing
    for (i = 0; i < 40; i++) random_item(55);

    // fill to capacity back to back
    no_idle = 1'b1;
    while (list_fill < pidl_pkg::DEPTH)
      send_word(pidl_pkg::OP_INSERT, 7'($urandom_range(list_fill + 1, 1)), pick_value());
    no_idle = 1'b0;

    // full list corner cases
    send_word(pidl_pkg::OP_INSERT, 7'd65,  32'd1);
    send_word(pidl_pkg::OP_INSERT, 7'd1,   32'd2);
    send_word(pidl_pkg::OP_INSERT, 7'd66,  32'd3);
    send_word(pidl_pkg::OP_DUMP,   7'd0,   32'd0);
    send_word(pidl_pkg::OP_DELETE, 7'd65,  32'd0);
    send_word(pidl_pkg::OP_DELETE, 7'd64,  32'd0);
    send_word(pidl_pkg::OP_INSERT, 7'd64,  32'h8000_0000);

    // hold off until the unit has drained
    in_tvalid <= 1'b0;
    while (pending_words != 0) @(negedge clk);

    // shrink, then mixed traffic again
    for (i = 0; i < 60; i++) random_item(20);
    for (i = 0; i < 50; i++) random_item(45);

    in_tvalid <= 1'b0;
    while (pending_words != 0) @(negedge clk);
    repeat (150) @(negedge clk);

    if (mismatch_count == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule

### positional_insert_delete_list_unit.f
+incdir+rtl/core
rtl/core/pidl_pkg.sv
rtl/core/pidl_ram.sv
rtl/core/positional_insert_delete_list_unit.sv
tb/pidl_list_monitor.sv
tb/tb_positional_insert_delete_list_unit.sv
